[src/sorted_nexthop_table_assert.svh]
// Assertion macros used by the next-hop table datapath
`ifndef SORTED_NEXTHOP_TABLE_ASSERT_SVH
`define SORTED_NEXTHOP_TABLE_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define SNT_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("next-hop table check failed");

// antecedent implies consequent in the next cycle
`define SNT_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-hop table check failed");

`endif

[src/snt_pkg.sv]
// Shared types for the sorted next-hop table
package snt_pkg;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_READ   = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_PRESENT   = 3'd1,
    ST_FULL      = 3'd2,
    ST_DELETED   = 3'd3,
    ST_NOT_FOUND = 3'd4,
    ST_READ_OK   = 3'd5,
    ST_EMPTY     = 3'd6,
    ST_UNUSED    = 3'd7
  } status_t;

  typedef struct packed {
    logic [31:0] addr;
    logic [15:0] cost;
    logic [7:0]  flag;
  } entry_t;

  typedef struct packed {
    logic    load_key;
    logic    ins_write;
    logic    del_start;
    logic    del_shift;
    logic    res_load;
    status_t res_status;
  } dp_cmd_t;

  typedef struct packed {
    cmd_t cmd;
    logic rd_ok;
    logic dup;
    logic full;
    logic any_eq;
    logic res_free;
  } dp_stat_t;

endpackage

[src/snt_ctrl.sv]
// Command sequencer for the sorted next-hop table
module snt_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  snt_pkg::dp_stat_t stat,
  output snt_pkg::dp_cmd_t  dcmd
);
  import snt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_DEL  = 3'b100
  } state_t;

  state_t state, state_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next      = state;
    dcmd            = '0;
    dcmd.res_status = ST_EMPTY;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          dcmd.load_key = 1'b1;
          state_next    = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (stat.cmd)
          CMD_INSERT: begin
            if (stat.res_free) begin
              dcmd.res_load = 1'b1;
              state_next    = S_IDLE;
              if (stat.dup) begin
                dcmd.res_status = ST_PRESENT;
              end else if (stat.full) begin
                dcmd.res_status = ST_FULL;
              end else begin
                dcmd.ins_write  = 1'b1;
                dcmd.res_status = ST_INSERTED;
              end
            end
          end
          CMD_DELETE: begin
            if (stat.any_eq) begin
              dcmd.del_start = 1'b1;
              dcmd.del_shift = 1'b1;
              state_next     = S_DEL;
            end else if (stat.res_free) begin
              dcmd.res_load   = 1'b1;
              dcmd.res_status = ST_NOT_FOUND;
              state_next      = S_IDLE;
            end
          end
          CMD_READ: begin
            if (stat.res_free) begin
              dcmd.res_load   = 1'b1;
              dcmd.res_status = stat.rd_ok ? ST_READ_OK : ST_EMPTY;
              state_next      = S_IDLE;
            end
          end
          default: begin
            if (stat.res_free) begin
              dcmd.res_load   = 1'b1;
              dcmd.res_status = ST_EMPTY;
              state_next      = S_IDLE;
            end
          end
        endcase
      end
      S_DEL: begin
        if (stat.any_eq) begin
          dcmd.del_shift = 1'b1;
        end else if (stat.res_free) begin
          dcmd.res_load   = 1'b1;
          dcmd.res_status = ST_DELETED;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

[src/snt_dp.sv]
// Entry cells, compare flags and result register of the next-hop table
`include "sorted_nexthop_table_assert.svh"

module snt_dp #(
  parameter int MAX_HOPS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  snt_pkg::dp_cmd_t  dcmd,
  output snt_pkg::dp_stat_t stat,
  input  logic [1:0]        cmd,
  input  logic [31:0]       hop_address,
  input  logic [15:0]       hop_cost,
  input  logic [7:0]        hop_flag,
  input  logic [3:0]        read_index,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [2:0]        status,
  output logic [3:0]        position,
  output logic [4:0]        removed_count,
  output logic [31:0]       out_address,
  output logic [15:0]       out_cost,
  output logic [7:0]        out_flag,
  output logic [4:0]        entry_count
);
  import snt_pkg::*;

  localparam int IW   = (MAX_HOPS > 2) ? $clog2(MAX_HOPS) : 1;
  localparam int CW   = $clog2(MAX_HOPS + 1);
  localparam int PW   = (IW > 4) ? IW : 4;
  localparam int EW   = (CW > 5) ? CW : 5;
  localparam int XW   = (CW > 4) ? CW : 4;
  localparam int RD_N = (MAX_HOPS < 16) ? MAX_HOPS : 16;

  cmd_t          key_cmd;
  entry_t        key;
  logic [3:0]    key_ridx;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic [IW-1:0] first_q;
  logic [CW-1:0] removed;

  entry_t ent_q  [MAX_HOPS];
  entry_t prev_e [MAX_HOPS];
  entry_t next_e [MAX_HOPS];

  logic [MAX_HOPS-1:0] vld, lt, eq, ge, dup, lt_prev, eq_prev, new_sel, first_sel;
  logic [IW-1:0] ins_pos, dup_pos, first_pos;
  logic          rd_ok;
  entry_t        rd_e;
  logic          full;
  logic          res_free;

  for (genvar g = 0; g < MAX_HOPS; g++) begin : g_cell
    assign vld[g] = CW'(g) < count;
    assign lt[g]  = vld[g] && (key.addr < ent_q[g].addr);
    assign eq[g]  = vld[g] && (key.addr == ent_q[g].addr);
    assign ge[g]  = lt[g] || eq[g];
    assign dup[g] = eq[g] && (key.cost == ent_q[g].cost) && (key.flag == ent_q[g].flag);

    if (g == 0) begin : g_head
      assign prev_e[g]  = key;
      assign lt_prev[g] = 1'b0;
      assign eq_prev[g] = 1'b0;
    end else begin : g_body
      assign prev_e[g]  = ent_q[g-1];
      assign lt_prev[g] = lt[g-1];
      assign eq_prev[g] = eq[g-1];
    end

    if (g == MAX_HOPS - 1) begin : g_tail
      assign next_e[g] = ent_q[g];
    end else begin : g_mid
      assign next_e[g] = ent_q[g+1];
    end

    assign new_sel[g]   = !lt_prev[g] && (lt[g] || (CW'(g) == count));
    assign first_sel[g] = eq[g] && !eq_prev[g];

    always_ff @(posedge clk) begin
      if (dcmd.ins_write) begin
        if (lt_prev[g]) begin
          ent_q[g] <= prev_e[g];
        end else if (new_sel[g]) begin
          ent_q[g] <= key;
        end
      end else if (dcmd.del_shift && ge[g]) begin
        ent_q[g] <= next_e[g];
      end
    end
  end

  // one-hot to index encoders
  always_comb begin
    ins_pos   = '0;
    dup_pos   = '0;
    first_pos = '0;
    for (int i = 0; i < MAX_HOPS; i++) begin
      ins_pos   = ins_pos   | (new_sel[i]   ? IW'(i) : '0);
      dup_pos   = dup_pos   | (dup[i]       ? IW'(i) : '0);
      first_pos = first_pos | (first_sel[i] ? IW'(i) : '0);
    end
  end

  always_comb begin
    rd_e = '0;
    for (int i = 0; i < RD_N; i++) begin
      if (key_ridx == 4'(i)) begin
        rd_e = ent_q[i];
      end
    end
  end

  assign rd_ok    = XW'(key_ridx) < XW'(count);
  assign full     = count == CW'(MAX_HOPS);
  assign res_free = !out_valid || !out_stall;

  assign stat.cmd      = key_cmd;
  assign stat.rd_ok    = rd_ok;
  assign stat.dup      = |dup;
  assign stat.full     = full;
  assign stat.any_eq   = |eq;
  assign stat.res_free = res_free;

  always_comb begin
    count_next = count;
    if (dcmd.ins_write) begin
      count_next = count + CW'(1);
    end else if (dcmd.del_shift) begin
      count_next = count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (dcmd.load_key) begin
      key_cmd   <= cmd_t'(cmd);
      key.addr  <= hop_address;
      key.cost  <= hop_cost;
      key.flag  <= hop_flag;
      key_ridx  <= read_index;
    end
    if (dcmd.del_start) begin
      first_q <= first_pos;
      removed <= CW'(1);
    end else if (dcmd.del_shift) begin
      removed <= removed + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  logic [PW-1:0] pos_ext;
  logic [EW-1:0] rem_ext;
  logic [EW-1:0] cnt_ext;

  always_comb begin
    pos_ext = '0;
    rem_ext = '0;
    case (dcmd.res_status)
      ST_INSERTED: pos_ext = PW'(ins_pos);
      ST_PRESENT:  pos_ext = PW'(dup_pos);
      ST_DELETED: begin
        pos_ext = PW'(first_q);
        rem_ext = EW'(removed);
      end
      ST_READ_OK:  pos_ext = PW'(key_ridx);
      default:     pos_ext = '0;
    endcase
    cnt_ext = EW'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (dcmd.res_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (dcmd.res_load) begin
      status        <= dcmd.res_status;
      position      <= pos_ext[3:0];
      removed_count <= rem_ext[4:0];
      entry_count   <= cnt_ext[4:0];
      if (dcmd.res_status == ST_READ_OK) begin
        out_address <= rd_e.addr;
        out_cost    <= rd_e.cost;
        out_flag    <= rd_e.flag;
      end else begin
        out_address <= '0;
        out_cost    <= '0;
        out_flag    <= '0;
      end
    end
  end

  `SNT_ASSERT_IMP(a_no_insert_when_full, clk, rst, dcmd.ins_write, !full && !(|dup))
  `SNT_ASSERT_IMP(a_shift_needs_match, clk, rst, dcmd.del_shift, (|eq) && (count != '0))
  `SNT_ASSERT_IMP(a_no_result_overwrite, clk, rst, dcmd.res_load, res_free)
  `SNT_ASSERT_NXT(a_count_grows_on_insert, clk, rst, dcmd.ins_write, count == $past(count) + CW'(1))

endmodule

[src/sorted_nexthop_table.sv]
// Top level of the sorted next-hop table: sequencer plus entry datapath
// Insert, read, unused codes and a missed delete load the result from the execute state.
// A matched delete then shifts the k removed entries out, one left shift per cycle.
// Results load once the result register is free; a new command waits until then (in_stall).
// The result register lets a new command start while the previous result waits.
// Reset clears the entry count and control state; entry cells hold no reset value.
module sorted_nexthop_table #(
  parameter int MAX_HOPS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  cmd,
  input  logic [31:0] hop_address,
  input  logic [15:0] hop_cost,
  input  logic [7:0]  hop_flag,
  input  logic [3:0]  read_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [3:0]  position,
  output logic [4:0]  removed_count,
  output logic [31:0] out_address,
  output logic [15:0] out_cost,
  output logic [7:0]  out_flag,
  output logic [4:0]  entry_count
);
  import snt_pkg::*;

  dp_cmd_t  dcmd;
  dp_stat_t stat;

  snt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .dcmd     (dcmd)
  );

  snt_dp #(
    .MAX_HOPS (MAX_HOPS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .dcmd          (dcmd),
    .stat          (stat),
    .cmd           (cmd),
    .hop_address   (hop_address),
    .hop_cost      (hop_cost),
    .hop_flag      (hop_flag),
    .read_index    (read_index),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .position      (position),
    .removed_count (removed_count),
    .out_address   (out_address),
    .out_cost      (out_cost),
    .out_flag      (out_flag),
    .entry_count   (entry_count)
  );

endmodule

[tb/sv/tb_sorted_nexthop_table.sv]
// Testbench for sorted_nexthop_table: directed rows then random route updates, checked per word
module tb_sorted_nexthop_table;
  timeunit 1ns;
  timeprecision 1ps;

  import snt_pkg::*;

  localparam int DEPTH = 16;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PRESSURE_AT = 300;
  localparam int PRESSURE_HOLD = 400;
  localparam int TAIL_CYCLES = 40;
  localparam int RANDOM_ITEMS = 930;
  localparam int MAX_PRINTS = 40;

  typedef struct packed {
    status_t     status;
    logic [3:0]  position;
    logic [4:0]  removed;
    entry_t      ent;
    logic [4:0]  count;
  } hop_reply_t;

  typedef struct {
    cmd_t        c;
    entry_t      e;
    logic [3:0]  idx;
    bit          typed;
    hop_reply_t  reply;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  cmd = CMD_NONE;
  logic [31:0] hop_address = '0;
  logic [15:0] hop_cost = '0;
  logic [7:0]  hop_flag = '0;
  logic [3:0]  read_index = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  status;
  logic [3:0]  position;
  logic [4:0]  removed_count;
  logic [31:0] out_address;
  logic [15:0] out_cost;
  logic [7:0]  out_flag;
  logic [4:0]  entry_count;

  entry_t      hop_tbl[DEPTH];
  int          hop_cnt = 0;
  hop_reply_t  replies_due[$];
  stim_row_t   plan[$];
  logic [31:0] addr_pool[6];
  int          n_sent = 0;
  int          n_checked = 0;
  int          n_errors = 0;
  int          idle_cycles = 0;

  always #4 clk = ~clk;

  sorted_nexthop_table #(.MAX_HOPS(DEPTH)) u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .cmd(cmd), .hop_address(hop_address), .hop_cost(hop_cost),
    .hop_flag(hop_flag), .read_index(read_index),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .position(position), .removed_count(removed_count),
    .out_address(out_address), .out_cost(out_cost), .out_flag(out_flag),
    .entry_count(entry_count)
  );

  function automatic hop_reply_t route_update(cmd_t c, entry_t e, logic [3:0] idx);
    hop_reply_t r;
    int slot, dup, first, gone, kept;
    r = '0;
    r.status = ST_EMPTY;
    case (c)
      CMD_INSERT: begin
        slot = hop_cnt;
        for (int i = hop_cnt - 1; i >= 0; i--) if (e.addr < hop_tbl[i].addr) slot = i;
        dup = -1;
        for (int i = slot - 1; i >= 0; i--) if (hop_tbl[i] == e) dup = i;
        if (dup >= 0) begin
          r.status = ST_PRESENT;
          r.position = 4'(dup);
        end else if (hop_cnt >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          for (int i = hop_cnt; i > slot; i--) hop_tbl[i] = hop_tbl[i - 1];
          hop_tbl[slot] = e;
          hop_cnt++;
          r.status = ST_INSERTED;
          r.position = 4'(slot);
        end
      end
      CMD_DELETE: begin
        first = -1;
        gone = 0;
        kept = 0;
        for (int i = 0; i < hop_cnt; i++) begin
          if (hop_tbl[i].addr == e.addr) begin
            if (first < 0) first = i;
            gone++;
          end else begin
            hop_tbl[kept] = hop_tbl[i];
            kept++;
          end
        end
        hop_cnt = kept;
        if (first >= 0) begin
          r.status = ST_DELETED;
          r.position = 4'(first);
          r.removed = 5'(gone);
        end else begin
          r.status = ST_NOT_FOUND;
        end
      end
      CMD_READ: begin
        if (idx < hop_cnt) begin
          r.status = ST_READ_OK;
          r.position = idx;
          r.ent = hop_tbl[idx];
        end
      end
      default: ;
    endcase
    r.count = 5'(hop_cnt);
    return r;
  endfunction

  function automatic hop_reply_t fixed_reply(status_t s, logic [3:0] p, logic [4:0] n);
    hop_reply_t r;
    r = '0;
    r.status = s;
    r.position = p;
    r.count = n;
    return r;
  endfunction

  function automatic void add_row(cmd_t c, logic [31:0] a, logic [15:0] co, logic [7:0] f,
                                  logic [3:0] idx, bit typed, hop_reply_t reply);
    stim_row_t row;
    row.c = c;
    row.e = {a, co, f};
    row.idx = idx;
    row.typed = typed;
    row.reply = reply;
    plan.push_back(row);
  endfunction

  function automatic logic [31:0] pick_address();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 6) return addr_pool[$urandom_range(0, 5)];
    if (roll < 8 && hop_cnt > 0) return hop_tbl[$urandom_range(0, hop_cnt - 1)].addr;
    if (roll == 9) return ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'h0;
    return $urandom;
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want_v);
    n_errors++;
    if (n_errors <= MAX_PRINTS)
      $display("mismatch on word %0d: %s got %0h expected %0h", n_checked, what, got, want_v);
  endtask

  task automatic check_reply();
    hop_reply_t want;
    if (replies_due.size() == 0) begin
      report_mismatch("unexpected word, status", status, 0);
      return;
    end
    want = replies_due.pop_front();
    if (status !== want.status) report_mismatch("status", status, want.status);
    if (position !== want.position) report_mismatch("position", position, want.position);
    if (removed_count !== want.removed)
      report_mismatch("removed_count", removed_count, want.removed);
    if (out_address !== want.ent.addr)
      report_mismatch("out_address", out_address, want.ent.addr);
    if (out_cost !== want.ent.cost) report_mismatch("out_cost", out_cost, want.ent.cost);
    if (out_flag !== want.ent.flag) report_mismatch("out_flag", out_flag, want.ent.flag);
    if (entry_count !== want.count) report_mismatch("entry_count", entry_count, want.count);
  endtask

  task automatic send_word(cmd_t c, entry_t e, logic [3:0] idx, bit typed, hop_reply_t reply);
    hop_reply_t pred;
    int gap;
    gap = ((n_sent / 80) % 3 == 2) ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= c;
    hop_address <= e.addr;
    hop_cost <= e.cost;
    hop_flag <= e.flag;
    read_index <= idx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pred = route_update(c, e, idx);
    replies_due.push_back(typed ? reply : pred);
    n_sent++;
  endtask

  // receiver: random hold-off per word, one long hold-off to back the table up
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        check_reply();
        n_checked++;
        if (n_checked == PRESSURE_AT) hold = PRESSURE_HOLD;
        else if ((n_checked / 50) % 4 == 1) hold = 0;
        else hold = $urandom_range(0, 16);
      end else if (hold > 0) begin
        hold--;
      end
      out_stall <= (hold > 0);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int mix, roll, ins_pct, del_pct;
    cmd_t c;
    entry_t e;

    addr_pool[0] = 32'h0;
    addr_pool[5] = 32'hFFFF_FFFF;

    // directed rows
    add_row(CMD_READ, 32'h0, 16'h0, 8'h0, 4'd0, 1'b1, fixed_reply(ST_EMPTY, 4'd0, 5'd0));
    add_row(CMD_DELETE, 32'h0, 16'h0, 8'h0, 4'd0, 1'b1,
            fixed_reply(ST_NOT_FOUND, 4'd0, 5'd0));
    add_row(CMD_NONE, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF, 4'hF, 1'b1,
            fixed_reply(ST_EMPTY, 4'd0, 5'd0));
    add_row(CMD_INSERT, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF, 4'hF, 1'b1,
            fixed_reply(ST_INSERTED, 4'd0, 5'd1));
    add_row(CMD_INSERT, 32'h0, 16'h0, 8'h0, 4'd0, 1'b1, fixed_reply(ST_INSERTED, 4'd0, 5'd2));
    add_row(CMD_INSERT, 32'h0, 16'h0, 8'h0, 4'd0, 1'b1, fixed_reply(ST_PRESENT, 4'd0, 5'd2));
    add_row(CMD_INSERT, 32'h0, 16'h1, 8'h0, 4'd0, 1'b0, '0);
    add_row(CMD_READ, 32'h0, 16'h0, 8'h0, 4'hF, 1'b1, fixed_reply(ST_EMPTY, 4'd0, 5'd3));
    add_row(CMD_READ, 32'h0, 16'h0, 8'h0, 4'd2, 1'b0, '0);
    for (int i = 0; i < 13; i++)
      add_row(CMD_INSERT, 32'h5A5A_5A5A, 16'(i * 4099), 8'(255 - i), 4'd0, 1'b0, '0);
    add_row(CMD_INSERT, 32'h1234_5678, 16'h7, 8'h7, 4'd0, 1'b1,
            fixed_reply(ST_FULL, 4'd0, 5'd16));
    add_row(CMD_INSERT, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF, 4'd0, 1'b0, '0);
    add_row(CMD_DELETE, 32'h5A5A_5A5A, 16'h0, 8'h0, 4'd0, 1'b0, '0);
    add_row(CMD_DELETE, 32'h0, 16'h0, 8'h0, 4'd0, 1'b0, '0);

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[r]) send_word(plan[r].c, plan[r].e, plan[r].idx, plan[r].typed, plan[r].reply);

    // random part: fill, balanced and drain phases over a small address pool
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      if (k % 150 == 0)
        for (int j = 1; j < 5; j++) addr_pool[j] = $urandom;
      mix = (k / 120) % 3;
      ins_pct = (mix == 0) ? 75 : (mix == 1) ? 45 : 20;
      del_pct = (mix == 2) ? 40 : 15;
      roll = $urandom_range(0, 99);
      if (roll < ins_pct) c = CMD_INSERT;
      else if (roll < ins_pct + del_pct) c = CMD_DELETE;
      else if (roll < 95) c = CMD_READ;
      else c = CMD_NONE;
      e.addr = pick_address();
      e.cost = ($urandom_range(0, 1) != 0) ? 16'($urandom_range(0, 3)) : 16'($urandom);
      e.flag = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 1)) : 8'($urandom);
      if (c == CMD_INSERT && hop_cnt > 0 && $urandom_range(0, 4) == 0)
        e = hop_tbl[$urandom_range(0, hop_cnt - 1)];
      if (c == CMD_DELETE && hop_cnt > 0 && $urandom_range(0, 9) < 7)
        e.addr = hop_tbl[$urandom_range(0, hop_cnt - 1)].addr;
      send_word(c, e, 4'($urandom_range(0, 15)), 1'b0, '0);
    end

    in_valid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (n_errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

[files.f]
+incdir+src
src/snt_pkg.sv
src/snt_ctrl.sv
src/snt_dp.sv
src/sorted_nexthop_table.sv
tb/sv/tb_sorted_nexthop_table.sv
